// ===== rtl/utd_pkg.sv =====
`default_nettype none

package utd_pkg;

  // store geometry
  localparam int URN_DEPTH         = 65536;
  localparam int MAX_REINFORCEMENT = 64;

  localparam int ADDR_W   = $clog2(URN_DEPTH);
  localparam int CNT_W    = $clog2(URN_DEPTH + 1);
  // wide enough for count plus appended balls and for any 16-bit field
  localparam int SUM_W    = ((CNT_W > 16) ? CNT_W : 16) + 2;
  localparam int RHO_BITS = $clog2(MAX_REINFORCEMENT + 1);
  localparam int ADD_W    = ((RHO_BITS > 7) ? RHO_BITS : 7) + 1;

  localparam int COLOR_W = 16;
  localparam int STORE_W = COLOR_W + 1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] draw_index;
  } item_t;

  typedef struct packed {
    logic [15:0] drawn_color;
    logic        was_novelty;
    logic [1:0]  status;
    logic [16:0] urn_size;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_CHECK,
    OP_LOAD,
    OP_LOAD_END,
    OP_DRAW,
    OP_APPEND,
    OP_POST
  } op_t;

  typedef struct packed {
    logic is_start;
    logic start_ok;
    logic idx_ok;
    logic fits;
    logic load_done;
    logic append_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/urn_triggering_draw.sv =====
`default_nettype none

// Polya urn with innovation triggering. A start transaction (cmd 0) refills the
// urn with colours 0 to initial_colors-1, all unmarked, writing one ball per
// cycle. A draw transaction (cmd 1) returns the colour at draw_index and
// whether it was unmarked, marks it, then appends balls one per cycle through
// the single store write port: nu+1 fresh colours and rho-nu-1 marked copies
// for an unmarked ball (copies first on the first draw after a start), rho
// copies for a marked one, both clamped to the reinforcement maximum. A
// flagged draw, with the index out of range or the urn full, changes nothing.
// One transaction is in work at a time; a finished result sits in an output
// register so the next item is taken while it waits. Store contents are
// undefined after reset; only balls loaded since the last start are ever read.
module urn_triggering_draw (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_stall,
  input  utd_pkg::item_t    item,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output utd_pkg::result_t  result,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import utd_pkg::*;

  // register map, word index
  localparam logic [1:0] REG_FRESH = 2'd0;
  localparam logic [1:0] REG_RHO   = 2'd1;
  localparam logic [1:0] REG_N0    = 2'd2;

  localparam logic [5:0]  FRESH_RESET = 6'd1;
  localparam logic [6:0]  RHO_RESET   = 7'd4;
  localparam logic [15:0] N0_RESET    = 16'd1;

  logic [5:0]  fresh_minus_one;
  logic [6:0]  reinforcement;
  logic [15:0] initial_colors;
  logic        reg_write;

  op_t         op;
  dp_status_t  dp_status;

  // registers take a write in the access phase; no wait states
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_minus_one <= FRESH_RESET;
      reinforcement   <= RHO_RESET;
      initial_colors  <= N0_RESET;
    end else if (reg_write) begin
      case (paddr[3:2])
        REG_FRESH: fresh_minus_one <= pwdata[5:0];
        REG_RHO:   reinforcement   <= pwdata[6:0];
        REG_N0:    initial_colors  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // read back, unused word reads as zero
  always_comb begin
    case (paddr[3:2])
      REG_FRESH: prdata = 32'(fresh_minus_one);
      REG_RHO:   prdata = 32'(reinforcement);
      REG_N0:    prdata = 32'(initial_colors);
      default:   prdata = '0;
    endcase
  end

  // sequencer: handshakes and one operation per cycle
  utd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .result_stall (result_stall),
    .status       (dp_status),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .op           (op)
  );

  // ball store, counters and the result register
  utd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .item            (item),
    .fresh_minus_one (fresh_minus_one),
    .reinforcement   (reinforcement),
    .initial_colors  (initial_colors),
    .status          (dp_status),
    .result          (result)
  );

endmodule

`default_nettype wire

// ===== rtl/utd_dp.sv =====
`default_nettype none

module utd_dp (
  input  logic                clk,
  input  logic                rst,
  input  utd_pkg::op_t        op,
  input  utd_pkg::item_t      item,
  input  logic [5:0]          fresh_minus_one,
  input  logic [6:0]          reinforcement,
  input  logic [15:0]         initial_colors,
  output utd_pkg::dp_status_t status,
  output utd_pkg::result_t    result
);
  import utd_pkg::*;

  logic [STORE_W-1:0] ball_store [URN_DEPTH];
  logic [STORE_W-1:0] rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [STORE_W-1:0] wr_data;

  logic               item_cmd;
  logic [15:0]        item_idx;

  logic [CNT_W-1:0]   ball_count;
  logic [COLOR_W-1:0] next_fresh;
  logic               first_pending;

  logic [ADD_W-1:0]   rho_c;
  logic [ADD_W-1:0]   fresh_c;
  logic [ADD_W-1:0]   copies_c;
  logic [ADD_W-1:0]   fresh_left;
  logic [ADD_W-1:0]   copy_left;
  logic               fresh_first;

  logic [COLOR_W-1:0] res_color;
  logic               res_novelty;
  logic [1:0]         res_status;

  logic [ADD_W-1:0]   rho_w;
  logic [ADD_W-1:0]   fresh_w;
  logic [ADD_W-1:0]   copies_w;
  logic [ADD_W-1:0]   added;
  logic               unmarked;
  logic               take_fresh;
  logic [SUM_W-1:0]   count_w;
  logic [SUM_W-1:0]   idx_w;
  logic [SUM_W-1:0]   sum_w;

  // clamped draw parameters
  always_comb begin
    rho_w = ADD_W'(reinforcement);
    if (ADD_W'(reinforcement) > ADD_W'(MAX_REINFORCEMENT)) begin
      rho_w = ADD_W'(MAX_REINFORCEMENT);
    end
    fresh_w = ADD_W'(fresh_minus_one) + ADD_W'(1);
    if (fresh_w > ADD_W'(MAX_REINFORCEMENT)) begin
      fresh_w = ADD_W'(MAX_REINFORCEMENT);
    end
    copies_w = (rho_w > fresh_w) ? (rho_w - fresh_w) : '0;
  end

  assign count_w    = SUM_W'(ball_count);
  assign idx_w      = SUM_W'(item_idx);
  assign unmarked   = !rd_data[STORE_W-1];
  assign added      = unmarked ? (copies_c + fresh_c) : rho_c;
  assign sum_w      = count_w + SUM_W'(added);
  assign take_fresh = fresh_first ? (fresh_left != '0) : (copy_left == '0);

  always_comb begin
    status.is_start    = (item_cmd == CMD_START);
    status.start_ok    = SUM_W'(initial_colors) <= SUM_W'(URN_DEPTH);
    status.idx_ok      = idx_w < count_w;
    status.fits        = sum_w <= SUM_W'(URN_DEPTH);
    status.load_done   = count_w == SUM_W'(initial_colors);
    status.append_done = (fresh_left == '0) && (copy_left == '0);
  end

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_w[ADDR_W-1:0];
    wr_data = {1'b0, count_w[COLOR_W-1:0]};
    case (op)
      OP_LOAD: begin
        wr_en = 1'b1;
      end
      OP_DRAW: begin
        wr_en   = status.fits;
        wr_addr = idx_w[ADDR_W-1:0];
        wr_data = {1'b1, rd_data[COLOR_W-1:0]};
      end
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_data = take_fresh ? {1'b0, next_fresh} : {1'b1, res_color};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ball_store[wr_addr] <= wr_data;
    end
    rd_data <= ball_store[idx_w[ADDR_W-1:0]];
  end

  // urn state
  always_ff @(posedge clk) begin
    if (rst) begin
      ball_count    <= '0;
      next_fresh    <= '0;
      first_pending <= 1'b1;
      fresh_left    <= '0;
      copy_left     <= '0;
    end else begin
      case (op)
        OP_CHECK: begin
          if (status.is_start && status.start_ok) begin
            ball_count <= '0;
          end
        end
        OP_LOAD: begin
          ball_count <= ball_count + CNT_W'(1);
        end
        OP_LOAD_END: begin
          next_fresh    <= initial_colors[COLOR_W-1:0];
          first_pending <= 1'b1;
        end
        OP_DRAW: begin
          if (status.fits) begin
            first_pending <= 1'b0;
            fresh_left    <= unmarked ? fresh_c : '0;
            copy_left     <= unmarked ? copies_c : rho_c;
          end
        end
        OP_APPEND: begin
          ball_count <= ball_count + CNT_W'(1);
          if (take_fresh) begin
            fresh_left <= fresh_left - ADD_W'(1);
            next_fresh <= next_fresh + COLOR_W'(1);
          end else begin
            copy_left <= copy_left - ADD_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        item_cmd <= item.cmd;
        item_idx <= item.draw_index;
      end
      OP_CHECK: begin
        rho_c       <= rho_w;
        fresh_c     <= fresh_w;
        copies_c    <= copies_w;
        res_color   <= '0;
        res_novelty <= 1'b0;
        if (status.is_start) begin
          res_status <= status.start_ok ? STATUS_OK : STATUS_FULL;
        end else begin
          res_status <= status.idx_ok ? STATUS_OK : STATUS_RANGE;
        end
      end
      OP_DRAW: begin
        if (status.fits) begin
          res_color   <= rd_data[COLOR_W-1:0];
          res_novelty <= unmarked;
          fresh_first <= unmarked && !first_pending;
        end else begin
          res_status <= STATUS_FULL;
        end
      end
      OP_POST: begin
        result.drawn_color <= res_color;
        result.was_novelty <= res_novelty;
        result.status      <= res_status;
        result.urn_size    <= count_w[16:0];
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= SUM_W'(URN_DEPTH))
    else $error("ball count beyond store depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    op == OP_APPEND |-> count_w < SUM_W'(URN_DEPTH))
    else $error("append with store full");
`endif

endmodule

`default_nettype wire

// ===== rtl/utd_ctrl.sv =====
`default_nettype none

module utd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                result_stall,
  input  utd_pkg::dp_status_t status,
  output logic                item_stall,
  output logic                result_valid,
  output utd_pkg::op_t        op
);
  import utd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_READ,
    S_APPEND,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          op         = OP_LATCH;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        op = OP_CHECK;
        if (status.is_start) begin
          state_next = status.start_ok ? S_LOAD : S_DONE;
        end else begin
          state_next = status.idx_ok ? S_READ : S_DONE;
        end
      end
      S_LOAD: begin
        if (status.load_done) begin
          op         = OP_LOAD_END;
          state_next = S_DONE;
        end else begin
          op = OP_LOAD;
        end
      end
      S_READ: begin
        op         = OP_DRAW;
        state_next = status.fits ? S_APPEND : S_DONE;
      end
      S_APPEND: begin
        if (status.append_done) begin
          state_next = S_DONE;
        end else begin
          op = OP_APPEND;
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          op         = OP_POST;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_POST) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_checks: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == S_CHECK)
    else $error("accepted transaction not checked next");

  a_post_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result posted outside done state");
`endif

endmodule

`default_nettype wire

// ===== test/urn_triggering_draw_test.sv =====
`default_nettype none

module urn_triggering_draw_test;
  timeunit 1ns;
  timeprecision 1ps;
  import utd_pkg::*;

  // register indexes, byte address is four times the index
  localparam int REG_FRESH_MINUS_ONE = 0;
  localparam int REG_REINFORCEMENT   = 1;
  localparam int REG_INITIAL_COLORS  = 2;

  localparam int RANDOM_ITEMS  = 1950;
  localparam int IDLE_PERCENT  = 22;
  // a short pause follows once every outstanding result is back
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 80;
  // watchdog bound on the whole run, big refills included
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int REPORT_LIMIT  = 10;

  // mirror of the urn: tracks the store, the counters and the registers and
  // works out the outcome of every accepted transaction
  class urn_mirror;
    logic [15:0] colour_at [URN_DEPTH];
    bit          marked [URN_DEPTH];
    int unsigned balls;
    int unsigned fresh_next;
    bit          first_pending;
    int unsigned nu;
    int unsigned rho;
    int unsigned n0;
    result_t     outcomes [$];
    int          errors;
    int          seen;
    int          items;
    int          starts;
    int          novelties;
    int          out_of_range;
    int          full_hits;

    function new();
      balls = 0;
      fresh_next = 0;
      first_pending = 1'b1;
      nu = 1;
      rho = 4;
      n0 = 1;
      errors = 0;
      seen = 0;
      items = 0;
      starts = 0;
      novelties = 0;
      out_of_range = 0;
      full_hits = 0;
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("ERROR: %s", msg);
    endfunction

    function void set_reg(int idx, logic [31:0] value);
      case (idx)
        REG_FRESH_MINUS_ONE: nu  = value[5:0];
        REG_REINFORCEMENT:   rho = value[6:0];
        REG_INITIAL_COLORS:  n0  = value[15:0];
        default: ;
      endcase
    endfunction

    function void put_copies(logic [15:0] colour, int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
        colour_at[balls] = colour;
        marked[balls] = 1'b1;
        balls++;
      end
    endfunction

    function void put_fresh(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
        colour_at[balls] = fresh_next[15:0];
        marked[balls] = 1'b0;
        balls++;
        fresh_next++;
      end
    endfunction

    function void play_item(item_t it);
      result_t     r;
      int unsigned idx;
      int unsigned eff_rho;
      int unsigned fresh;
      int unsigned copies;
      int unsigned added;
      bit          unmarked;
      logic [15:0] c;
      r = '0;
      idx = it.draw_index;
      items++;
      if (it.cmd == CMD_START) begin
        // n0 is 16 bits, so a refill always fits the store
        for (int unsigned i = 0; i < n0; i++) begin
          colour_at[i] = i[15:0];
          marked[i] = 1'b0;
        end
        balls = n0;
        fresh_next = n0;
        first_pending = 1'b1;
        starts++;
      end else if (idx >= balls) begin
        r.status = STATUS_RANGE;
        out_of_range++;
      end else begin
        eff_rho = (rho > MAX_REINFORCEMENT) ? MAX_REINFORCEMENT : rho;
        fresh = nu + 1;
        if (fresh > MAX_REINFORCEMENT)
          fresh = MAX_REINFORCEMENT;
        unmarked = !marked[idx];
        if (unmarked) begin
          copies = (eff_rho > fresh) ? eff_rho - fresh : 0;
          added = copies + fresh;
        end else begin
          copies = eff_rho;
          added = eff_rho;
        end
        if (balls + added > URN_DEPTH) begin
          // nothing changes, not even the mark
          r.status = STATUS_FULL;
          full_hits++;
        end else begin
          c = colour_at[idx];
          r.drawn_color = c;
          r.was_novelty = unmarked;
          marked[idx] = 1'b1;
          // the first draw after a refill puts its copies ahead of the fresh colours
          if (unmarked && !first_pending) begin
            put_fresh(fresh);
            put_copies(c, copies);
          end else begin
            put_copies(c, copies);
            if (unmarked)
              put_fresh(fresh);
          end
          if (unmarked)
            novelties++;
          first_pending = 1'b0;
        end
      end
      r.urn_size = balls[16:0];
      outcomes = {outcomes, r};
    endfunction

    function void check_field(string name, logic [16:0] want, logic [16:0] got);
      if (got !== want)
        complain($sformatf("result %0d %s: expected %0d, got %0d", seen, name, want, got));
    endfunction

    function void compare_outcome(result_t got);
      result_t want;
      seen++;
      if (outcomes.size() == 0) begin
        complain($sformatf("result %0d arrived with nothing outstanding", seen));
        return;
      end
      want = outcomes.pop_front();
      check_field("drawn_color", want.drawn_color, got.drawn_color);
      check_field("was_novelty", want.was_novelty, got.was_novelty);
      check_field("status", want.status, got.status);
      check_field("urn_size", want.urn_size, got.urn_size);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // set during one random phase to run both sides flat out
  bit          steady = 1'b0;
  urn_mirror   urn = new();

  urn_triggering_draw DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // every accepted result transaction is checked against the oldest outstanding one
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      urn.compare_outcome(result);
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // one register write: setup cycle then access cycle, psel left high so that
  // writes can follow back to back
  task automatic write_reg(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    urn.set_reg(idx, value);
  endtask

  task automatic configure(input int unsigned nu, input int unsigned rho,
                           input int unsigned n0);
    write_reg(REG_FRESH_MINUS_ONE, nu);
    write_reg(REG_REINFORCEMENT, rho);
    write_reg(REG_INITIAL_COLORS, n0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offers one transaction, with a random gap first unless steady, and holds it until taken
  task automatic send_item(input logic cmd, input logic [15:0] idx);
    item_t it;
    it.cmd = cmd;
    it.draw_index = idx;
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    urn.play_item(it);
  endtask

  // block goes idle: every outstanding result back, then a short pause
  task automatic settle();
    item_valid <= 1'b0;
    while (urn.outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          random_items;
    int          phase;
    int          span;
    int unsigned nu;
    int unsigned rho;
    int unsigned n0;
    int unsigned pick;
    int unsigned cnt;
    logic        cmd;
    logic [15:0] idx;

    random_items = 0;
    phase = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: nu 1, rho 4, one colour
    // draws into an empty urn before any start
    send_item(CMD_DRAW, 16'd0);
    send_item(CMD_DRAW, 16'hFFFF);
    send_item(CMD_START, 16'hFFFF);
    send_item(CMD_DRAW, 16'd1);
    // first draw: two copies of colour 0, then fresh colours 1 and 2
    send_item(CMD_DRAW, 16'd0);
    // marked ball: four copies
    send_item(CMD_DRAW, 16'd0);
    // later novelty: fresh colours first, then copies
    send_item(CMD_DRAW, 16'd3);
    settle();

    // largest nu, rho above the maximum, empty refill
    configure(63, 127, 0);
    send_item(CMD_START, 16'd0);
    send_item(CMD_DRAW, 16'd0);
    settle();
    configure(63, 127, 3);
    send_item(CMD_START, 16'd0);
    send_item(CMD_DRAW, 16'd2);
    send_item(CMD_DRAW, 16'd66);
    settle();

    // rho below nu plus one: a novelty adds fresh colours only
    configure(5, 2, 3);
    send_item(CMD_DRAW, 16'd0);
    send_item(CMD_DRAW, 16'd0);
    settle();
    // zero rho: a marked draw adds nothing
    configure(5, 0, 3);
    send_item(CMD_DRAW, 16'd0);
    send_item(CMD_DRAW, 16'd1);
    settle();

    // fullest refill, then fill the store to its last entry
    configure(0, 1, 65535);
    send_item(CMD_START, 16'd0);
    send_item(CMD_DRAW, 16'hFFFF);
    send_item(CMD_DRAW, 16'hFFFE);
    send_item(CMD_DRAW, 16'd0);
    send_item(CMD_DRAW, 16'hFFFF);
    send_item(CMD_DRAW, 16'hFFFE);
    settle();
    configure(0, 0, 65535);
    send_item(CMD_DRAW, 16'hFFFE);
    send_item(CMD_DRAW, 16'hFFFF);
    settle();

    // random phases: a refill, then mostly in-range draws with some noise
    while (random_items < RANDOM_ITEMS) begin
      steady <= (phase == 1);
      nu = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
      pick = $urandom_range(0, 9);
      if (pick == 0)
        rho = $urandom_range(0, 127);
      else if (pick == 1)
        rho = MAX_REINFORCEMENT;
      else
        rho = $urandom_range(nu + 1, nu + 10);
      if (phase == 4) begin
        // one big urn driven into the full case
        n0 = $urandom_range(60000, 65535);
        rho = MAX_REINFORCEMENT;
      end else if ($urandom_range(0, 19) == 0) begin
        n0 = 0;
      end else begin
        n0 = $urandom_range(1, 300);
      end
      configure(nu, rho, n0);
      span = $urandom_range(60, 220);
      send_item(CMD_START, 16'($urandom));
      random_items++;
      for (int k = 0; k < span && random_items < RANDOM_ITEMS; k++) begin
        cnt = urn.balls;
        pick = $urandom_range(0, 99);
        cmd = CMD_DRAW;
        idx = 16'($urandom);
        if (pick < 3)
          cmd = CMD_START;
        else if (pick < 9)
          ;
        else if (pick < 12 && cnt < URN_DEPTH)
          idx = 16'(cnt);
        else if (cnt > 0)
          idx = 16'($urandom_range(0, cnt - 1));
        send_item(cmd, idx);
        random_items++;
      end
      settle();
      phase++;
    end
    steady <= 1'b0;

    item_valid <= 1'b0;
    while (urn.outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (urn.outcomes.size() != 0)
      urn.complain($sformatf("%0d results never arrived", urn.outcomes.size()));

    $display("run covered %0d transactions over %0d random phases: %0d refills, %0d novelties",
             urn.items, phase, urn.starts, urn.novelties);
    $display("flagged draws: %0d out of range, %0d with the urn full; %0d errors",
             urn.out_of_range, urn.full_hits, urn.errors);
    if (urn.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/utd_pkg.sv
rtl/utd_dp.sv
rtl/utd_ctrl.sv
rtl/urn_triggering_draw.sv
test/urn_triggering_draw_test.sv
